FILE: rtl/mbet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and constants for the four-lane multibrot escape-time block.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int LANES_DEF     = 4;
    localparam int FRAC_BITS_DEF = 27;
    localparam int CNT_W         = 16;
    localparam int PWR_W         = 3;

    localparam logic [CNT_W-1:0] MAX_ITER_RST = 16'd256;
    localparam logic [PWR_W-1:0] POWER_RST    = 3'd1;

    // register byte addresses
    localparam logic [2:0] ADDR_MAX_ITER = 3'd0;
    localparam logic [2:0] ADDR_POWER    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RR,
        ST_SQ_II,
        ST_SQ_RI,
        ST_ADD,
        ST_ROUND,
        ST_OUT
    } state_t;

endpackage : mbet_pkg
`default_nettype wire

FILE: rtl/multibrot_escape_time_4lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multibrot_escape_time_4lane
// Escape-time iteration over a group of complex points on one shared
// multiplier, with saturating fixed-point arithmetic.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Content
// s_axis    in   s_axis_tvalid/tready   LANES points c (re, im)
// m_axis    out  m_axis_tvalid/tready   LANES escape counts, remaining count
// apb       in   psel/penable/pwrite    max_iterations, power
//
// One item takes up to max_iterations rounds; each round squares each lane's z
// power times (clamped to 1..4) and adds c, all on the single 32x32 multiplier
// (one product a cycle). The loop stops early once every lane has escaped.
// Reset clears control state and restores the register defaults.
// The block takes no new word until its result word is taken.
// ----------------------------------------------------------------------------
module multibrot_escape_time_4lane #(
    parameter int LANES     = mbet_pkg::LANES_DEF,
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // c_re_0, c_im_0, c_re_1, c_im_1, ... from bit 0 up
    input  wire  [LANES*64-1:0]                   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // escape_count_0 .. escape_count_(LANES-1), remaining_count from bit 0 up
    output logic [(LANES+1)*mbet_pkg::CNT_W-1:0]  m_axis_tdata,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [2:0]                            paddr,
    input  wire  [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int CW = mbet_pkg::CNT_W;
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic signed [63:0] SMAX = 64'sd2147483647;
    localparam logic signed [63:0] SMIN = -64'sd2147483648;
    localparam logic signed [63:0] LIM4 = 64'sd4 <<< FRAC_BITS;

    mbet_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              max_iter_reg;
    logic [mbet_pkg::PWR_W-1:0] power_reg;
    logic signed [31:0] cre_reg [LANES];
    logic signed [31:0] cim_reg [LANES];
    logic signed [31:0] zr_reg  [LANES];
    logic signed [31:0] zi_reg  [LANES];
    logic [CW-1:0]      res_reg [LANES];
    logic [LANES-1:0]   esc_reg;
    logic signed [31:0] re2_reg, im2_reg;
    logic               clamp_reg;
    logic [CW-1:0]      count_reg, remain_reg;
    logic [LW-1:0]      lane_reg;
    logic [2:0]         sq_reg, sq_lim_reg;

    // ---- configuration port
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr)
            mbet_pkg::ADDR_MAX_ITER: prdata = {16'd0, max_iter_reg};
            mbet_pkg::ADDR_POWER:    prdata = {29'd0, power_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= mbet_pkg::MAX_ITER_RST;
            power_reg    <= mbet_pkg::POWER_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == mbet_pkg::ADDR_MAX_ITER)
                max_iter_reg <= pwdata[CW-1:0];
            else if (paddr == mbet_pkg::ADDR_POWER)
                power_reg <= pwdata[mbet_pkg::PWR_W-1:0];
        end
    end

    // ---- shared multiplier and saturation
    logic signed [31:0] zr_cur, zi_cur, mul_a, mul_b;
    logic signed [63:0] prod, prod_sh;
    logic signed [63:0] prod_sat;
    logic               prod_clamp;
    assign zr_cur = zr_reg[lane_reg];
    assign zi_cur = zi_reg[lane_reg];

    always_comb
    begin
        case (state_reg)
            mbet_pkg::ST_SQ_RR: begin mul_a = zr_cur; mul_b = zr_cur; end
            mbet_pkg::ST_SQ_II: begin mul_a = zi_cur; mul_b = zi_cur; end
            default:            begin mul_a = zr_cur; mul_b = zi_cur; end
        endcase
        prod    = 64'(mul_a) * 64'(mul_b);
        prod_sh = prod >>> FRAC_BITS;  // arithmetic shift is floor
        prod_clamp = (prod_sh > SMAX) || (prod_sh < SMIN);
        prod_sat   = (prod_sh > SMAX) ? SMAX : ((prod_sh < SMIN) ? SMIN : prod_sh);
    end

    // cross term step: re = sat(re2-im2), im = sat(2t)
    logic signed [63:0] dre, dim;
    logic signed [31:0] new_zr, new_zi;
    logic               cross_clamp;
    always_comb
    begin
        dre = 64'(re2_reg) - 64'(im2_reg);
        dim = prod_sat <<< 1;
        new_zr = (dre > SMAX) ? 32'sh7fffffff : ((dre < SMIN) ? 32'sh80000000 : dre[31:0]);
        new_zi = (dim > SMAX) ? 32'sh7fffffff : ((dim < SMIN) ? 32'sh80000000 : dim[31:0]);
        cross_clamp = prod_clamp || (dre > SMAX) || (dre < SMIN)
                      || (dim > SMAX) || (dim < SMIN);
    end

    // add step: z += c, and escape test
    logic signed [63:0] are, aim, mag2;
    logic signed [31:0] add_zr, add_zi;
    logic               lane_esc;
    always_comb
    begin
        are  = 64'(zr_cur) + 64'(cre_reg[lane_reg]);
        aim  = 64'(zi_cur) + 64'(cim_reg[lane_reg]);
        mag2 = 64'(re2_reg) + 64'(im2_reg);
        add_zr = (are > SMAX) ? 32'sh7fffffff : ((are < SMIN) ? 32'sh80000000 : are[31:0]);
        add_zi = (aim > SMAX) ? 32'sh7fffffff : ((aim < SMIN) ? 32'sh80000000 : aim[31:0]);
        lane_esc = clamp_reg || (are > SMAX) || (are < SMIN) || (aim > SMAX)
                   || (aim < SMIN) || (mag2 > LIM4);
    end

    logic last_lane, last_sq, all_esc;
    assign last_lane = (lane_reg == LW'(LANES-1));
    assign last_sq   = (sq_reg == sq_lim_reg);
    assign all_esc   = &esc_reg;

    // ---- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbet_pkg::ST_IDLE:
                if (s_axis_tvalid)
                    state_next = (max_iter_reg == '0) ? mbet_pkg::ST_OUT
                                                      : mbet_pkg::ST_SQ_RR;
            mbet_pkg::ST_SQ_RR: state_next = mbet_pkg::ST_SQ_II;
            mbet_pkg::ST_SQ_II: state_next = mbet_pkg::ST_SQ_RI;
            mbet_pkg::ST_SQ_RI: state_next = last_sq ? mbet_pkg::ST_ADD
                                                     : mbet_pkg::ST_SQ_RR;
            mbet_pkg::ST_ADD:   state_next = last_lane ? mbet_pkg::ST_ROUND
                                                       : mbet_pkg::ST_SQ_RR;
            mbet_pkg::ST_ROUND:
                if (all_esc || count_reg == CW'(1))
                    state_next = mbet_pkg::ST_OUT;
                else
                    state_next = mbet_pkg::ST_SQ_RR;
            mbet_pkg::ST_OUT:
                if (m_axis_tready)
                    state_next = mbet_pkg::ST_IDLE;
            default: state_next = mbet_pkg::ST_IDLE;
        endcase
    end

    // ---- outputs
    always_comb
    begin
        s_axis_tready = (state_reg == mbet_pkg::ST_IDLE);
        m_axis_tvalid = (state_reg == mbet_pkg::ST_OUT);
        for (int l = 0; l < LANES; l++)
            m_axis_tdata[l*CW +: CW] = res_reg[l];
        m_axis_tdata[LANES*CW +: CW] = remain_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbet_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---- datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mbet_pkg::ST_IDLE:
                if (s_axis_tvalid)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        cre_reg[l] <= s_axis_tdata[l*64 +: 32];
                        cim_reg[l] <= s_axis_tdata[l*64+32 +: 32];
                        zr_reg[l]  <= s_axis_tdata[l*64 +: 32];
                        zi_reg[l]  <= s_axis_tdata[l*64+32 +: 32];
                        res_reg[l] <= '0;
                    end
                    esc_reg    <= '0;
                    remain_reg <= '0;
                    count_reg  <= max_iter_reg;
                    lane_reg   <= '0;
                    sq_reg     <= 3'd1;
                    clamp_reg  <= 1'b0;
                    if (power_reg == 3'd0)
                        sq_lim_reg <= 3'd1;
                    else if (power_reg > 3'd4)
                        sq_lim_reg <= 3'd4;
                    else
                        sq_lim_reg <= power_reg;
                end
            mbet_pkg::ST_SQ_RR:
            begin
                re2_reg   <= prod_sat[31:0];
                clamp_reg <= clamp_reg | prod_clamp;
            end
            mbet_pkg::ST_SQ_II:
            begin
                im2_reg   <= prod_sat[31:0];
                clamp_reg <= clamp_reg | prod_clamp;
            end
            mbet_pkg::ST_SQ_RI:
            begin
                zr_reg[lane_reg] <= new_zr;
                zi_reg[lane_reg] <= new_zi;
                clamp_reg <= clamp_reg | cross_clamp;
                sq_reg    <= last_sq ? 3'd1 : sq_reg + 3'd1;
            end
            mbet_pkg::ST_ADD:
            begin
                zr_reg[lane_reg] <= add_zr;
                zi_reg[lane_reg] <= add_zi;
                if (!esc_reg[lane_reg] && lane_esc)
                begin
                    esc_reg[lane_reg] <= 1'b1;
                    res_reg[lane_reg] <= count_reg;
                end
                clamp_reg <= 1'b0;
                lane_reg  <= last_lane ? '0 : lane_reg + LW'(1);
            end
            mbet_pkg::ST_ROUND:
            begin
                if (all_esc)
                    remain_reg <= count_reg;
                count_reg <= count_reg - CW'(1);
            end
            mbet_pkg::ST_OUT: ;
            default: ;
        endcase
    end

endmodule : multibrot_escape_time_4lane
`default_nettype wire
